[sv/spv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spv_pkg: shared types and constants for the sun position vector
// Fixed-point formats, elaboration-time constant builders and CORDIC tables.
// ----------------------------------------------------------------------------
package spv_pkg;

  localparam int ANGLE_FRACTION_BITS = 32;
  localparam int TRIG_STEPS = 32;
  localparam int RES_W = ANGLE_FRACTION_BITS - 2;
  localparam int OUT_W = 39;

  typedef logic signed [63:0] word_t;
  typedef logic [63:0] phase_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] x;
  } result_t;

  localparam logic [63:0] HALF_PI = 64'h6487ED5110B4611A;
  localparam logic [63:0] QUARTER_PI = 64'h3243F6A8885A308D;
  localparam logic [55:0] EPOCH_Q32 = 56'(64'd2451545 << 32);

  function automatic logic [63:0] frac_bits(logic [63:0] num, logic [63:0] den, int bits);
    logic [63:0] rem;
    logic [63:0] q;
    rem = num;
    q = '0;
    for (int i = 0; i < bits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv(logic [63:0] n, logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      q = q << 1;
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_entry(int i);
    logic [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) begin
      acc = QUARTER_PI;
    end else begin
      for (int k = 0; k < 32; k++) begin
        e = i * (2 * k + 1);
        if (e <= 62) begin
          term = udiv(64'd1 << (62 - e), 64'(2 * k + 1));
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  localparam logic [63:0] RATE = frac_bits(64'd999973583, 64'd365250000000, 64);
  localparam logic [63:0] M0 = frac_bits(64'd9931267, 64'd10000000, 64);
  localparam logic [63:0] LON0 = frac_bits(64'd7859444, 64'd10000000, 64);
  localparam logic [63:0] EQC1 = frac_bits(64'd6892, 64'd1296000, 64);
  localparam logic [63:0] EQC2 = frac_bits(64'd72, 64'd1296000, 64);
  localparam logic [63:0] GAIN =
    frac_bits(64'd607252935008881256, 64'd1000000000000000000, 62);
  localparam logic [63:0] COS_EPS =
    frac_bits(64'd917482062069181825, 64'd1000000000000000000, 62);
  localparam logic [63:0] SIN_EPS =
    frac_bits(64'd397777155931913714, 64'd1000000000000000000, 62);
  localparam logic [63:0] RAD0 = 64'd149619000000 << 16;
  localparam logic [63:0] RAD1 = 64'd2499000000 << 16;
  localparam logic [63:0] RAD2 = 64'd21000000 << 16;

endpackage
`default_nettype wire

[sv/spv_phase.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spv_phase: mean anomaly from Julian date
// Epoch offset, split rate multiply and wrapped Q0.64 sum, three stages.
// ----------------------------------------------------------------------------
module spv_phase (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [54:0]   date_q32,
  output logic               out_valid,
  output spv_pkg::phase_t    phase
);

  logic               v1, v2;
  logic signed [23:0] dh;
  logic [31:0]        dl;
  logic signed [56:0] pa;
  logic [31:0]        pb;
  logic [63:0]        pc;
  logic [31:0]        pd;
  logic [55:0]        d;
  logic signed [56:0] ph;
  logic [63:0]        pdl;
  logic [63:0]        sum;

  always_comb begin
    d = {1'b0, date_q32} - spv_pkg::EPOCH_Q32;
    ph = dh * $signed({1'b0, spv_pkg::RATE[63:32]});
    pdl = dl * spv_pkg::RATE[31:0];
    sum = spv_pkg::M0 + 64'(pa) + {pb, 32'd0} + pc + {32'd0, pd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dh <= d[55:32];
      dl <= d[31:0];
      pa <= dh * $signed({1'b0, spv_pkg::RATE[31:0]});
      pb <= ph[31:0];
      pc <= dl * spv_pkg::RATE[63:32];
      pd <= pdl[63:32];
      phase <= {sum[63 -: spv_pkg::ANGLE_FRACTION_BITS],
                (64 - spv_pkg::ANGLE_FRACTION_BITS)'(0)};
    end
  end

endmodule
`default_nettype wire

[sv/spv_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spv_cordic: pipelined sine and cosine of a turn phase
// Quadrant split, radian scaling, one rotation per stage, quadrant fold.
// ----------------------------------------------------------------------------
module spv_cordic (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire spv_pkg::phase_t phase,
  input  wire spv_pkg::word_t  tag_in,
  output logic                 out_valid,
  output spv_pkg::word_t       sin_out,
  output spv_pkg::word_t       cos_out,
  output spv_pkg::word_t       tag_out
);

  localparam int N = spv_pkg::TRIG_STEPS;
  localparam int RW = spv_pkg::RES_W;

  logic                pv;
  logic [1:0]          pq;
  spv_pkg::word_t      pt;
  logic [RW+31:0]      pp0;
  logic [RW+30:0]      pp1;
  logic [RW+63:0]      zsum;

  logic                vs [N+1];
  logic [1:0]          qs [N+1];
  spv_pkg::word_t      ts [N+1];
  spv_pkg::word_t      xs [N+1];
  spv_pkg::word_t      ys [N+1];
  spv_pkg::word_t      zs [N+1];

  always_comb begin
    zsum = (RW+64)'(pp0) + ((RW+64)'(pp1) << 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
      vs[0] <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
      vs[0] <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq <= phase[63:62];
      pt <= tag_in;
      pp0 <= phase[61 -: RW] * spv_pkg::HALF_PI[31:0];
      pp1 <= phase[61 -: RW] * spv_pkg::HALF_PI[62:32];
      qs[0] <= pq;
      ts[0] <= pt;
      xs[0] <= spv_pkg::GAIN;
      ys[0] <= '0;
      zs[0] <= 64'(zsum >> RW);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam spv_pkg::word_t ATAN = spv_pkg::atan_entry(i);
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        qs[i+1] <= qs[i];
        ts[i+1] <= ts[i];
        if (!zs[i][63]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_out <= ts[N];
      case (qs[N])
        2'd0: begin
          cos_out <= xs[N];
          sin_out <= ys[N];
        end
        2'd1: begin
          cos_out <= -ys[N];
          sin_out <= xs[N];
        end
        2'd2: begin
          cos_out <= -xs[N];
          sin_out <= -ys[N];
        end
        default: begin
          cos_out <= ys[N];
          sin_out <= -xs[N];
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/spv_mulq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spv_mulq: pipelined Q62 signed multiply
// Product of two signed words shifted right by 62, truncated toward zero.
// ----------------------------------------------------------------------------
module spv_mulq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire spv_pkg::word_t a,
  input  wire spv_pkg::word_t b,
  input  wire spv_pkg::word_t tag_in,
  output logic                out_valid,
  output spv_pkg::word_t      prod,
  output spv_pkg::word_t      tag_out
);

  logic           v1, v2, v3;
  logic           n1, n2, n3;
  spv_pkg::word_t t1, t2, t3;
  logic [63:0]    ua, ub;
  logic [63:0]    pp00, pp01, pp10, pp11;
  logic [62:0]    mag;
  logic [127:0]   full;

  always_comb begin
    full = {64'd0, pp00} + ({64'd0, pp01} << 32) + ({64'd0, pp10} << 32) + {pp11, 64'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua <= a[63] ? 64'(-a) : a;
      ub <= b[63] ? 64'(-b) : b;
      n1 <= a[63] ^ b[63];
      t1 <= tag_in;
      pp00 <= ua[31:0] * ub[31:0];
      pp01 <= ua[31:0] * ub[63:32];
      pp10 <= ua[63:32] * ub[31:0];
      pp11 <= ua[63:32] * ub[63:32];
      n2 <= n1;
      t2 <= t1;
      mag <= full[124:62];
      n3 <= n2;
      t3 <= t2;
      prod <= n3 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      tag_out <= t3;
    end
  end

endmodule
`default_nettype wire

[sv/spv_skid.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spv_skid: two-entry output buffer
// Holds finished results and gives a registered advance to the pipeline.
// ----------------------------------------------------------------------------
module spv_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire spv_pkg::result_t in_data,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spv_pkg::result_t      out_data
);

  logic [1:0]       count;
  spv_pkg::result_t e1;
  logic             push, pop;

  always_comb begin
    advance = (count != 2'd2);
    out_valid = (count != 2'd0);
    push = advance && in_valid;
    pop = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= push ? in_data : e1;
    end else if (push && count == 2'd0) begin
      out_data <= in_data;
    end
    if (push && !pop && count == 2'd1) begin
      e1 <= in_data;
    end
  end

endmodule
`default_nettype wire

[sv/sun_position_vector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sun_position_vector: low-precision Sun position in the inertial frame
// One Julian date in, one Sun vector in whole metres out.
//
// s_tdata carries the Julian date (unsigned Q23.32 days) in bits 54:0.
// m_tdata carries sun_x, sun_y, sun_z (39-bit signed metres) from bit 0 up.
// Every date gives exactly one result, in order.
// Throughput: one item per cycle while s_tready is high, set by the fully pipelined
// rotation units and split multipliers; every stage holds one item.
// Path from the accepting edge to the earliest result handshake, in order:
// phase, two CORDIC units in parallel, equation-of-centre multiply, sum,
// longitude CORDIC, two multiply ranks, rounding, buffer.
// A two-entry output buffer absorbs receiver stalls; s_tready drops only
// when both entries are full, and the whole pipeline then holds in place.
// Reset (rst, synchronous) empties the pipeline and the buffer.
// ----------------------------------------------------------------------------
module sun_position_vector (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [55:0]   s_tdata,   // date[54:0], pad
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [119:0]       m_tdata    // sun_x[38:0], sun_y[38:0], sun_z[38:0], pad
);

  logic             en;
  logic             pm_v, c1_v, c2_v, k1_v, l_v, c3_v, e_v, f_v, rnd_v;
  spv_pkg::phase_t  pm, m2;
  spv_pkg::word_t   sm, cm, s2, c2, m_t1, m_t2;
  spv_pkg::word_t   corr1, corr2, ra, rb, m_t3;
  spv_pkg::phase_t  l;
  spv_pkg::word_t   r, sl, cl, r_t, ex, ey, yv, zv, ex_t;
  spv_pkg::result_t rnd, head;

  function automatic logic signed [spv_pkg::OUT_W-1:0] metres(spv_pkg::word_t v);
    spv_pkg::word_t s;
    s = (v + 64'sd32768) >>> 16;
    return s[spv_pkg::OUT_W-1:0];
  endfunction

  assign s_tready = en;
  assign m2 = pm << 1;

  spv_phase u_phase (
    .clk, .rst, .en, .in_valid(s_tvalid), .date_q32(s_tdata[54:0]),
    .out_valid(pm_v), .phase(pm)
  );

  spv_cordic u_trig_m (
    .clk, .rst, .en, .in_valid(pm_v), .phase(pm), .tag_in(pm),
    .out_valid(c1_v), .sin_out(sm), .cos_out(cm), .tag_out(m_t1)
  );

  spv_cordic u_trig_2m (
    .clk, .rst, .en, .in_valid(pm_v), .phase(m2), .tag_in('0),
    .out_valid(c2_v), .sin_out(s2), .cos_out(c2), .tag_out(m_t2)
  );

  spv_mulq u_eqc1 (
    .clk, .rst, .en, .in_valid(c1_v), .a(sm), .b(spv_pkg::EQC1), .tag_in(m_t1),
    .out_valid(k1_v), .prod(corr1), .tag_out(m_t3)
  );

  spv_mulq u_eqc2 (
    .clk, .rst, .en, .in_valid(c2_v), .a(s2), .b(spv_pkg::EQC2), .tag_in(m_t2),
    .out_valid(), .prod(corr2), .tag_out()
  );

  spv_mulq u_rad1 (
    .clk, .rst, .en, .in_valid(c1_v), .a(spv_pkg::RAD1), .b(cm), .tag_in('0),
    .out_valid(), .prod(ra), .tag_out()
  );

  spv_mulq u_rad2 (
    .clk, .rst, .en, .in_valid(c2_v), .a(spv_pkg::RAD2), .b(c2), .tag_in('0),
    .out_valid(), .prod(rb), .tag_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v <= 1'b0;
    end else if (en) begin
      l_v <= k1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l <= m_t3 + spv_pkg::LON0 + corr1 + corr2;
      r <= spv_pkg::RAD0 - ra - rb;
    end
  end

  spv_cordic u_trig_l (
    .clk, .rst, .en, .in_valid(l_v), .phase(l), .tag_in(r),
    .out_valid(c3_v), .sin_out(sl), .cos_out(cl), .tag_out(r_t)
  );

  spv_mulq u_ecl_x (
    .clk, .rst, .en, .in_valid(c3_v), .a(r_t), .b(cl), .tag_in('0),
    .out_valid(e_v), .prod(ex), .tag_out()
  );

  spv_mulq u_ecl_y (
    .clk, .rst, .en, .in_valid(c3_v), .a(r_t), .b(sl), .tag_in('0),
    .out_valid(), .prod(ey), .tag_out()
  );

  spv_mulq u_eq_y (
    .clk, .rst, .en, .in_valid(e_v), .a(ey), .b(spv_pkg::COS_EPS), .tag_in(ex),
    .out_valid(f_v), .prod(yv), .tag_out(ex_t)
  );

  spv_mulq u_eq_z (
    .clk, .rst, .en, .in_valid(e_v), .a(ey), .b(spv_pkg::SIN_EPS), .tag_in('0),
    .out_valid(), .prod(zv), .tag_out()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_v <= 1'b0;
    end else if (en) begin
      rnd_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd.x <= metres(ex_t);
      rnd.y <= metres(yv);
      rnd.z <= metres(zv);
    end
  end

  spv_skid u_skid (
    .clk, .rst, .in_valid(rnd_v), .in_data(rnd), .advance(en),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(head)
  );

  assign m_tdata = {3'd0, head};

endmodule
`default_nettype wire

[tb/sv/sun_position_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sun_position_checker: ephemeris predictor and scoreboard
// Watches both stream channels, computes the Sun vector for every accepted
// date and compares it with the results in order, reporting mismatches per field.
// ----------------------------------------------------------------------------
module sun_position_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [55:0]  s_tdata,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [119:0] m_tdata,
  output int                errors,
  output int                pending
);

  localparam longint unsigned Q16_ONE = 64'd65536;

  logic [116:0] sun_vectors[$];
  logic [63:0] arctan_tab[spv_pkg::TRIG_STEPS];

  function automatic longint unsigned frac_of(longint unsigned num, longint unsigned den,
                                              int bits);
    longint unsigned q;
    longint unsigned rem;
    q = 0;
    rem = num;
    for (int i = 0; i < bits; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] scale_mul(logic signed [63:0] a,
                                                    logic signed [63:0] b, int sh);
    logic [127:0] p;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] mag;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    p = {64'd0, ua} * {64'd0, ub};
    mag = 64'(p >> sh);
    mag[63] = 1'b0;
    return (a[63] != b[63]) ? -$signed(mag) : $signed(mag);
  endfunction

  task automatic sincos(input logic [63:0] phase, output logic signed [63:0] s,
                        output logic signed [63:0] c);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] nx;
    logic [1:0] quad;
    phase = phase & ~((64'd1 << (64 - spv_pkg::ANGLE_FRACTION_BITS)) - 64'd1);
    quad = phase[63:62];
    z = scale_mul($signed({2'b00, phase[61:0]}), $signed(spv_pkg::HALF_PI), 62);
    x = $signed(frac_of(64'd607252935008881256, 64'd1000000000000000000, 62));
    y = 0;
    for (int i = 0; i < spv_pkg::TRIG_STEPS && i < 63; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - $signed(arctan_tab[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + $signed(arctan_tab[i]);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  function automatic logic [38:0] whole_metres(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd32768) >>> 16;
    return r[38:0];
  endfunction

  task automatic predict_vector(input logic [54:0] jd, output logic [116:0] vec);
    logic signed [63:0] d;
    logic signed [63:0] dh;
    logic [63:0] dl;
    logic [63:0] rate;
    logic [63:0] m;
    logic [63:0] l;
    logic signed [63:0] sm, cm, s2, c2, sl, cl, corr, r, ex, ey, vy, vz;
    d = $signed({9'd0, jd}) - (64'sd2451545 <<< 32);
    dh = d >>> 32;
    dl = {32'd0, d[31:0]};
    rate = frac_of(64'd999973583, 64'd365250000000, 64);
    m = frac_of(64'd9931267, 64'd10000000, 64) + dh * rate + dl * (rate >> 32)
        + ((dl * (rate & 64'hFFFFFFFF)) >> 32);
    m = m & ~((64'd1 << (64 - spv_pkg::ANGLE_FRACTION_BITS)) - 64'd1);
    sincos(m, sm, cm);
    sincos(m << 1, s2, c2);
    corr = scale_mul(sm, $signed(frac_of(64'd6892, 64'd1296000, 64)), 62)
         + scale_mul(s2, $signed(frac_of(64'd72, 64'd1296000, 64)), 62);
    l = m + frac_of(64'd7859444, 64'd10000000, 64) + corr;
    sincos(l, sl, cl);
    r = $signed(64'd149619000000 * Q16_ONE)
      - scale_mul($signed(64'd2499000000 * Q16_ONE), cm, 62)
      - scale_mul($signed(64'd21000000 * Q16_ONE), c2, 62);
    ex = scale_mul(r, cl, 62);
    ey = scale_mul(r, sl, 62);
    vy = scale_mul(ey, $signed(frac_of(64'd917482062069181825, 64'd1000000000000000000,
                                       62)), 62);
    vz = scale_mul(ey, $signed(frac_of(64'd397777155931913714, 64'd1000000000000000000,
                                       62)), 62);
    vec = {whole_metres(vz), whole_metres(vy), whole_metres(ex)};
  endtask

  initial begin
    longint acc;
    longint term;
    int e;
    for (int i = 0; i < spv_pkg::TRIG_STEPS; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = 64'h3243F6A8885A308D;
      end else if (i < 63) begin
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e > 62) break;
          term = longint'((64'd1 << (62 - e)) / (2 * k + 1));
          acc = k[0] ? acc - term : acc + term;
        end
      end
      arctan_tab[i] = acc;
    end
  end

  always @(posedge clk) begin
    logic [116:0] want;
    logic [116:0] got;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_vector(s_tdata[54:0], want);
        sun_vectors.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[116:0];
        if (sun_vectors.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", got);
          errors <= errors + 1;
        end else begin
          want = sun_vectors.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch x exp %0d got %0d, y exp %0d got %0d, z exp %0d got %0d",
                       $signed(want[38:0]), $signed(got[38:0]),
                       $signed(want[77:39]), $signed(got[77:39]),
                       $signed(want[116:78]), $signed(got[116:78]));
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= sun_vectors.size();
  end
endmodule
`default_nettype wire

[tb/sv/tb_sun_position_vector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sun_position_vector: stream testbench for the Sun position block
// Drives directed and random Julian dates in bursts with gaps, stalls the
// result side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_sun_position_vector;
  localparam int NUM_RANDOM = 1700;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [54:0] EPOCH_JD = 55'(64'd2451545 << 32);

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [55:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [119:0] m_tdata;
  int errors;
  int pending;
  int idle_cycles;
  logic [54:0] dates[$];

  sun_position_vector dut (.*);
  sun_position_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [54:0] random_date(int mode);
    logic [54:0] v;
    v = 55'({$urandom(), $urandom()});
    case (mode)
      0: return v;
      1: return EPOCH_JD + 55'($signed(32'($urandom())) * 64'sd200);
      default: return EPOCH_JD + 55'({$urandom_range(0, 100000), $urandom()});
    endcase
  endfunction

  task automatic send_date(input logic [54:0] jd);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, jd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int gap;
    int burst;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    dates = '{55'd0, {55{1'b1}}, EPOCH_JD, EPOCH_JD - 55'd1, EPOCH_JD + 55'd1,
              55'h2AAAAAAAAAAAAA, 55'h55555555555555, 55'd1, 55'h40000000000000,
              55'h3FFFFFFFFFFFFF, EPOCH_JD + 55'(64'd36525 << 32),
              EPOCH_JD - 55'(64'd36525 << 32), EPOCH_JD + 55'(64'd91 << 32),
              EPOCH_JD + 55'(64'd183 << 32), EPOCH_JD + 55'(64'd274 << 32),
              55'(64'd2460000 << 32)};
    foreach (dates[i]) send_date(dates[i]);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++)
        send_date(random_date($urandom_range(0, 2)));
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

[sun_position_vector.f]
sv/spv_pkg.sv
sv/spv_phase.sv
sv/spv_cordic.sv
sv/spv_mulq.sv
sv/spv_skid.sv
sv/sun_position_vector.sv
tb/sv/sun_position_checker.sv
tb/sv/tb_sun_position_vector.sv
